[rtl/rprc_pkg.sv]
package rprc_pkg;

    // Field widths fixed by the host protocol
    localparam int POWER_W   = 16;
    localparam int CODE_W    = 8;
    localparam int MS_W      = 16;
    localparam int OP_W      = 2;
    localparam int REG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int TDATA_W   = 32;

    // Operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_TICK         = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_OUTPUT   = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_SETPOINT = 2'd2;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_RAMP_ENABLE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_UP_MS   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_DOWN_MS = 2'd2;

    // Configuration reset values
    localparam logic [MS_W-1:0] RAMP_MS_RESET = 16'd1000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic ramp_setup;
        logic step_size;
        logic ramp_apply;
        logic tick_move;
        logic tick_settle;
        logic load_result;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ramp_go;
        logic            div_done;
    } dp_status_t;

endpackage

[rtl/rf_power_ramp_controller.sv]
// Flow: a tick beat passes exec, tick move and tick settle before its result
// is loaded; a command that needs no ramp goes from exec to the load; a
// ramp-starting command also waits on the bit-serial step-size divider.
// Throughput: one item at a time; the next beat can be taken in the cycle after the
// result is loaded, even while that result still waits on m_tready.
// Reset (rst_n, async low): output off, power, setpoint and ramp cleared.
module rf_power_ramp_controller
    import rprc_pkg::*;
#(
    parameter int TICK_MS   = 100,
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // command_code[7:0], turn_on[8], setpoint_value[24:9]
    input  logic [OP_W-1:0]      s_tuser,   // operation[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // command_echo[7:0], status_code[8],
                                            // forward_power[24:9], output_on[25],
                                            // ramp_running[26]
    output logic                 m_tuser,   // is_reply[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rprc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rprc_datapath #(
        .TICK_MS   (TICK_MS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/rprc_divider.sv]
module rprc_divider
    import rprc_pkg::*;
#(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 16,
    parameter int CNT_W      = $clog2(DIVIDEND_W + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    input  logic [CNT_W-1:0]      count,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = count;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/rprc_datapath.sv]
module rprc_datapath
    import rprc_pkg::*;
#(
    parameter int TICK_MS   = 100,
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic                 m_tuser
);

    localparam int ACC_W    = POWER_W + FRAC_BITS;
    localparam int EXT_W    = ACC_W + 2;
    localparam int CNT_W    = $clog2(ACC_W + 1);
    localparam int RECIP_SH = MS_W + $clog2(TICK_MS);
    localparam int PROD_W   = RECIP_SH + MS_W;
    localparam logic [MS_W:0]    RECIP        =
        (MS_W + 1)'(((64'd1 << RECIP_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));
    localparam logic [ACC_W:0]   ROUND_HALF   = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [CNT_W-1:0] CNT_SIZE     = CNT_W'(ACC_W);
    localparam int PAD_W = TDATA_W - (CODE_W + 1 + POWER_W + 2);

    // Configuration
    logic                 ramp_enable_reg;
    logic [MS_W-1:0]      ramp_up_ms_reg;
    logic [MS_W-1:0]      ramp_down_ms_reg;

    // Captured item
    logic [OP_W-1:0]      op_reg;
    logic [CODE_W-1:0]    code_reg;
    logic                 turn_on_reg;
    logic [POWER_W-1:0]   value_reg;

    // Ramp state
    logic [POWER_W-1:0]   setpoint_reg, setpoint_next;
    logic [POWER_W-1:0]   present_reg, present_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     step_reg, step_next;
    logic [POWER_W-1:0]   target_reg, target_next;
    logic                 active_reg, active_next;
    logic                 rf_reg, rf_next;

    // Working registers
    logic                 toward_reg, toward_next;
    logic [POWER_W-1:0]   diff_reg, diff_next;
    logic [MS_W-1:0]      n_reg;
    logic                 moved_reg, moved_next;

    // Result register
    logic [TDATA_W-1:0]   res_tdata_reg;
    logic                 res_tuser_reg;

    // Divider hookup
    logic                 div_start;
    logic [ACC_W-1:0]     div_dividend;
    logic [MS_W-1:0]      div_divisor;
    logic [CNT_W-1:0]     div_count;
    logic                 div_done;
    logic [ACC_W-1:0]     div_quotient;

    // Combinational helpers
    logic [ACC_W:0]       round_sum;
    logic [POWER_W:0]     acc_round;
    logic [POWER_W-1:0]   target_sel;
    logic [MS_W-1:0]      ms_sel;
    logic [PROD_W-1:0]    steps_prod;
    logic [MS_W-1:0]      steps_q;
    logic [MS_W-1:0]      n_sat;
    logic [EXT_W-1:0]     acc_e;
    logic [EXT_W-1:0]     tgt_e;
    logic [EXT_W-1:0]     step2_e;
    logic [POWER_W-1:0]   present_new;
    logic                 is_reply;

    // Round the accumulator half up to whole watts
    assign round_sum = {1'b0, acc_reg} + ROUND_HALF;
    assign acc_round = round_sum[ACC_W:FRAC_BITS];

    assign acc_e   = {2'b00, acc_reg};
    assign tgt_e   = {2'b00, target_reg, {FRAC_BITS{1'b0}}};
    assign step2_e = {1'b0, step_reg, 1'b0};

    assign target_sel = toward_reg ? setpoint_reg : '0;
    assign present_new = moved_reg ? acc_round[POWER_W-1:0] : present_reg;
    assign is_reply = (op_reg == OP_SET_OUTPUT) || (op_reg == OP_SET_SETPOINT);

    // Count the ticks of a ramp by reciprocal multiplication, never below one
    assign steps_prod = PROD_W'(ms_sel) * PROD_W'(RECIP);
    assign steps_q    = steps_prod[PROD_W-1:RECIP_SH];
    assign n_sat      = (steps_q == '0) ? MS_W'(1) : steps_q;

    // Size the step with the bit-serial divider
    assign div_start    = cmd.step_size;
    assign div_dividend = {diff_reg, {FRAC_BITS{1'b0}}};
    assign div_divisor  = n_reg;
    assign div_count    = CNT_SIZE;

    rprc_divider #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (MS_W),
        .CNT_W      (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .count    (div_count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Pick direction, difference and ramp time
    always_comb
    begin
        if (target_sel > present_reg)
        begin
            ms_sel    = ramp_up_ms_reg;
            diff_next = target_sel - present_reg;
        end
        else if (target_sel < present_reg)
        begin
            ms_sel    = ramp_down_ms_reg;
            diff_next = present_reg - target_sel;
        end
        else
        begin
            ms_sel    = ramp_up_ms_reg;
            diff_next = '0;
        end
    end

    // Next ramp state
    always_comb
    begin
        setpoint_next = setpoint_reg;
        present_next  = present_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        target_next   = target_reg;
        active_next   = active_reg;
        rf_next       = rf_reg;
        toward_next   = toward_reg;
        moved_next    = moved_reg;

        // Apply commands that do not ramp
        if (cmd.exec)
        begin
            toward_next = (op_reg == OP_SET_SETPOINT) || turn_on_reg;
            if ((op_reg == OP_SET_OUTPUT) && (rf_reg != turn_on_reg) && !ramp_enable_reg)
            begin
                present_next = turn_on_reg ? setpoint_reg : '0;
                rf_next      = turn_on_reg;
            end
            if (op_reg == OP_SET_SETPOINT)
            begin
                setpoint_next = value_reg;
                if (!ramp_enable_reg && rf_reg)
                begin
                    present_next = value_reg;
                end
            end
        end

        if (cmd.ramp_setup)
        begin
            target_next = target_sel;
        end

        // Start the ramp once the step size is known
        if (cmd.ramp_apply)
        begin
            step_next   = (div_quotient == '0) ? ACC_W'(1) : div_quotient;
            acc_next    = {present_reg, {FRAC_BITS{1'b0}}};
            active_next = 1'b1;
            if (toward_reg)
            begin
                rf_next = 1'b1;
            end
        end

        // Advance the accumulator one step, snap when the next would pass
        if (cmd.tick_move)
        begin
            moved_next = 1'b0;
            if (active_reg && (acc_round != {1'b0, target_reg}))
            begin
                moved_next = 1'b1;
                if (acc_e < tgt_e)
                begin
                    if (acc_e + step2_e > tgt_e)
                        acc_next = tgt_e[ACC_W-1:0];
                    else
                        acc_next = acc_reg + step_reg;
                end
                else if (acc_e > tgt_e)
                begin
                    if (acc_e < tgt_e + step2_e)
                        acc_next = tgt_e[ACC_W-1:0];
                    else
                        acc_next = acc_reg - step_reg;
                end
            end
        end

        // Update power and end the ramp at the target
        if (cmd.tick_settle && active_reg)
        begin
            present_next = present_new;
            if (present_new == target_reg)
            begin
                active_next = 1'b0;
                acc_next    = '0;
                if (present_new == '0)
                begin
                    rf_next = 1'b0;
                end
            end
        end
    end

    // Hold configuration and ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_enable_reg  <= 1'b1;
            ramp_up_ms_reg   <= RAMP_MS_RESET;
            ramp_down_ms_reg <= RAMP_MS_RESET;
            setpoint_reg     <= '0;
            present_reg      <= '0;
            acc_reg          <= '0;
            step_reg         <= '0;
            target_reg       <= '0;
            active_reg       <= 1'b0;
            rf_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_RAMP_ENABLE:  ramp_enable_reg  <= cfg_data[0];
                    REG_RAMP_UP_MS:   ramp_up_ms_reg   <= cfg_data;
                    REG_RAMP_DOWN_MS: ramp_down_ms_reg <= cfg_data;
                    default:          ;
                endcase
            end
            setpoint_reg <= setpoint_next;
            present_reg  <= present_next;
            acc_reg      <= acc_next;
            step_reg     <= step_next;
            target_reg   <= target_next;
            active_reg   <= active_next;
            rf_reg       <= rf_next;
        end
    end

    // Hold item, working values and the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= s_tuser;
            code_reg    <= s_tdata[CODE_W-1:0];
            turn_on_reg <= s_tdata[CODE_W];
            value_reg   <= s_tdata[CODE_W+POWER_W:CODE_W+1];
        end
        if (cmd.ramp_setup)
        begin
            diff_reg <= diff_next;
            n_reg    <= n_sat;
        end
        toward_reg <= toward_next;
        moved_reg  <= moved_next;
        if (cmd.load_result)
        begin
            res_tdata_reg <= {{PAD_W{1'b0}}, active_reg, rf_reg, present_reg, 1'b0,
                              is_reply ? code_reg : {CODE_W{1'b0}}};
            res_tuser_reg <= is_reply;
        end
    end

    assign status.op       = op_reg;
    assign status.ramp_go  = ramp_enable_reg &&
                             (((op_reg == OP_SET_OUTPUT) && (rf_reg != turn_on_reg)) ||
                              (op_reg == OP_SET_SETPOINT));
    assign status.div_done = div_done;

    assign m_tdata = res_tdata_reg;
    assign m_tuser = res_tuser_reg;

endmodule

[rtl/rprc_ctrl.sv]
module rprc_ctrl
    import rprc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK_MOVE,
        ST_TICK_SETTLE,
        ST_SETUP,
        ST_DIV_START,
        ST_DIV_SIZE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            // Dispatch on the operation
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.op == OP_TICK)
                    state_next = ST_TICK_MOVE;
                else if (status.ramp_go)
                    state_next = ST_SETUP;
                else
                    state_next = ST_FINISH;
            end
            ST_TICK_MOVE:
            begin
                cmd.tick_move = 1'b1;
                state_next    = ST_TICK_SETTLE;
            end
            ST_TICK_SETTLE:
            begin
                cmd.tick_settle = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_SETUP:
            begin
                cmd.ramp_setup = 1'b1;
                state_next     = ST_DIV_START;
            end
            // Start sizing the step once tick count and difference are held
            ST_DIV_START:
            begin
                cmd.step_size = 1'b1;
                state_next    = ST_DIV_SIZE;
            end
            ST_DIV_SIZE:
            begin
                if (status.div_done)
                begin
                    cmd.ramp_apply = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            // Load the result beat once the output register frees up
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[rtl/rprc_checker.sv]
module rprc_checker
    import rprc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Keep the payload of a stalled result beat steady
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Status is always accepted
    a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8] == 1'b0))
        else $error("nonzero status code");

    // Results that are not replies (ticks and unused operations) carry no command byte
    a_tick_echo: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[7:0] == 8'd0))
        else $error("tick result with command echo");

endmodule

bind rf_power_ramp_controller rprc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/rprc_ramp_checker.sv]
`timescale 1ns / 100ps

module rprc_ramp_checker
    import rprc_pkg::*;
#(
    parameter int TICK_MS   = 100,
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [TDATA_W-1:0]   m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   outstanding
);

    typedef struct packed {
        logic               is_reply;
        logic [CODE_W-1:0]  echo;
        logic               status;
        logic [POWER_W-1:0] power;
        logic               rf_on;
        logic               running;
    } ramp_result_t;

    // Shadow copy of the configuration registers
    logic            ramp_en;
    logic [MS_W-1:0] up_ms;
    logic [MS_W-1:0] down_ms;

    // Shadow copy of the ramp state
    logic [POWER_W-1:0] setpoint_w;
    logic [POWER_W-1:0] power_w;
    logic [POWER_W-1:0] target_w;
    logic [63:0]        acc_fx;
    logic [63:0]        step_fx;
    logic               ramping;
    logic               rf_on;

    ramp_result_t result_q[$];

    // Number of ticks a ramp is spread over, never below one
    function automatic logic [63:0] ramp_ticks(input logic [MS_W-1:0] ms);
        logic [63:0] n;
        n = ms / TICK_MS;
        return (n == 0) ? 64'd1 : n;
    endfunction

    // Fixed-point accumulator to whole watts, rounding half up
    function automatic logic [31:0] to_watts(input logic [63:0] acc);
        return 32'((acc + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    endfunction

    // Load step, target and accumulator for a new ramp
    function automatic void start_ramp(input logic toward_setpoint);
        logic [63:0]        diff;
        logic [63:0]        n;
        logic [POWER_W-1:0] goal;
        diff = 64'd0;
        n    = 64'd1;
        goal = toward_setpoint ? setpoint_w : '0;
        if (goal > power_w)
        begin
            diff = goal - power_w;
            n    = ramp_ticks(up_ms);
        end
        else if (goal < power_w)
        begin
            diff = power_w - goal;
            n    = ramp_ticks(down_ms);
        end
        step_fx = (diff << FRAC_BITS) / n;
        if (step_fx == 0)
            step_fx = 64'd1;
        target_w = goal;
        acc_fx   = {48'd0, power_w} << FRAC_BITS;
        if (toward_setpoint)
            rf_on = 1'b1;
        ramping = 1'b1;
    endfunction

    // Move the accumulator one step, snapping to the target near the end
    function automatic void advance_tick();
        logic [63:0] goal_fx;
        logic [31:0] watts;
        if (!ramping)
            return;
        goal_fx = {48'd0, target_w} << FRAC_BITS;
        if (to_watts(acc_fx) != {16'd0, target_w})
        begin
            if (acc_fx < goal_fx)
            begin
                if (acc_fx + 2 * step_fx > goal_fx)
                    acc_fx = goal_fx;
                else
                    acc_fx = acc_fx + step_fx;
            end
            else if (acc_fx > goal_fx)
            begin
                if (acc_fx < goal_fx + 2 * step_fx)
                    acc_fx = goal_fx;
                else
                    acc_fx = acc_fx - step_fx;
            end
            watts   = to_watts(acc_fx);
            power_w = watts[POWER_W-1:0];
        end
        if (power_w == target_w)
        begin
            ramping = 1'b0;
            acc_fx  = 64'd0;
            if (power_w == 0)
                rf_on = 1'b0;
        end
    endfunction

    // Apply one input beat to the shadow state and form its result
    function automatic ramp_result_t apply_item(input logic [OP_W-1:0]    op,
                                                input logic [CODE_W-1:0]  code,
                                                input logic               turn_on,
                                                input logic [POWER_W-1:0] value);
        ramp_result_t r;
        r.is_reply = 1'b0;
        case (op)
            OP_TICK:
                advance_tick();
            OP_SET_OUTPUT:
            begin
                r.is_reply = 1'b1;
                if (rf_on != turn_on)
                begin
                    if (ramp_en)
                        start_ramp(turn_on);
                    else
                    begin
                        power_w = turn_on ? setpoint_w : '0;
                        rf_on   = turn_on;
                    end
                end
            end
            OP_SET_SETPOINT:
            begin
                r.is_reply = 1'b1;
                setpoint_w = value;
                if (ramp_en)
                    start_ramp(1'b1);
                else if (rf_on)
                    power_w = setpoint_w;
            end
            default:
                ;
        endcase
        r.echo    = r.is_reply ? code : '0;
        r.status  = 1'b0;
        r.power   = power_w;
        r.rf_on   = rf_on;
        r.running = ramping;
        return r;
    endfunction

    // Track config writes, predict each input beat, check each output beat
    always @(posedge clk or negedge rst_n)
    begin : watch
        ramp_result_t want;
        ramp_result_t got;
        logic         bad;
        if (!rst_n)
        begin
            ramp_en     = 1'b1;
            up_ms       = RAMP_MS_RESET;
            down_ms     = RAMP_MS_RESET;
            setpoint_w  = '0;
            power_w     = '0;
            target_w    = '0;
            acc_fx      = 64'd0;
            step_fx     = 64'd0;
            ramping     = 1'b0;
            rf_on       = 1'b0;
            result_q.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RAMP_ENABLE:  ramp_en = cfg_data[0];
                    REG_RAMP_UP_MS:   up_ms   = cfg_data[MS_W-1:0];
                    REG_RAMP_DOWN_MS: down_ms = cfg_data[MS_W-1:0];
                    default:          ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got.is_reply = m_tuser;
                got.echo     = m_tdata[7:0];
                got.status   = m_tdata[8];
                got.power    = m_tdata[24:9];
                got.rf_on    = m_tdata[25];
                got.running  = m_tdata[26];
                if (result_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result beat with nothing pending: reply=%0d echo=%02h",
                                 $realtime, got.is_reply, got.echo);
                    errors <= errors + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    bad  = (got.is_reply !== want.is_reply) || (got.echo !== want.echo)
                        || (got.status !== want.status) || (got.power !== want.power)
                        || (got.rf_on !== want.rf_on) || (got.running !== want.running);
                    if (bad)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected reply=%0d echo=%02h status=%0d power=%0d on=%0d ramp=%0d",
                                     want.is_reply, want.echo, want.status, want.power,
                                     want.rf_on, want.running);
                            $display("  actual   reply=%0d echo=%02h status=%0d power=%0d on=%0d ramp=%0d",
                                     got.is_reply, got.echo, got.status, got.power,
                                     got.rf_on, got.running);
                        end
                        errors <= errors + 1;
                    end
                end
            end

            if (s_tvalid && s_tready)
                result_q.push_back(apply_item(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[24:9]));

            outstanding <= result_q.size();
        end
    end

endmodule

[tb/tb_rf_power_ramp_controller.sv]
`timescale 1ns / 100ps

module tb_rf_power_ramp_controller;
    import rprc_pkg::*;

    localparam int TICK_MS        = 100;
    localparam int FRAC_BITS      = 16;
    localparam int SEG_ITEMS      = 325;
    localparam int WATCHDOG_LIMIT = 2000;

    // Codes outside the defined sets, still legal on the wires
    localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = OP_TICK;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = REG_RAMP_ENABLE;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int errors;
    int outstanding;
    int tx_idle_pct  = 13;
    int rx_idle_pct  = 50;
    int stall_cycles = 0;

    always #5 clk = ~clk;

    rf_power_ramp_controller #(
        .TICK_MS   (TICK_MS),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rprc_ramp_checker #(
        .TICK_MS   (TICK_MS),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Stall the result side at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Abort when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one input beat after a random gap and hold it until taken
    task automatic send_beat(input logic [OP_W-1:0]    op,
                             input logic [CODE_W-1:0]  code,
                             input logic               turn_on,
                             input logic [POWER_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, value, turn_on, code};
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold off input until every pending result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [OP_W-1:0]    op;
        logic [POWER_W-1:0] value;
        logic               en;
        logic [MS_W-1:0]    up;
        logic [MS_W-1:0]    dn;
        int                 sent;
        int                 run;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short ramps up, single-step ramps down
        write_reg(REG_RAMP_UP_MS, 16'd300);
        write_reg(REG_RAMP_DOWN_MS, 16'd0);
        write_reg(REG_SPARE, 16'hFFFF);

        // Tick with no ramp, then switch on with a zero setpoint
        send_beat(OP_TICK, 8'hFF, 1'b1, 16'hFFFF);
        send_beat(OP_SET_OUTPUT, 8'h00, 1'b1, 16'h0000);
        send_beat(OP_TICK, 8'h00, 1'b0, 16'h0000);
        // Ramp up to full scale, then ask for the level already reached
        send_beat(OP_SET_SETPOINT, 8'hA5, 1'b0, 16'hFFFF);
        repeat (4) send_beat(OP_TICK, 8'h5A, 1'b1, 16'h8001);
        send_beat(OP_SET_SETPOINT, 8'h5A, 1'b1, 16'hFFFF);
        send_beat(OP_TICK, 8'hC3, 1'b0, 16'h7FFE);
        // Switch on while on, then off with a sub-tick ramp
        send_beat(OP_SET_OUTPUT, 8'h11, 1'b1, 16'h0000);
        send_beat(OP_SET_OUTPUT, 8'h22, 1'b0, 16'hFFFF);
        repeat (2) send_beat(OP_TICK, 8'h3C, 1'b1, 16'h1234);
        send_beat(OP_UNUSED, 8'hEE, 1'b1, 16'hFFFF);

        // Ramping off: power follows commands at once
        wait_idle();
        write_reg(REG_RAMP_ENABLE, 16'hFFFE);
        send_beat(OP_SET_SETPOINT, 8'h33, 1'b0, 16'd1234);
        send_beat(OP_SET_OUTPUT, 8'h44, 1'b1, 16'h0000);
        send_beat(OP_SET_SETPOINT, 8'h55, 1'b0, 16'hFFFF);
        send_beat(OP_SET_OUTPUT, 8'h66, 1'b0, 16'h0000);
        send_beat(OP_TICK, 8'h77, 1'b0, 16'h0000);

        // Random segments: a command followed by a burst of ticks
        for (int seg = 0; seg < 6; seg++)
        begin
            wait_idle();
            case (seg / 2)
                0:
                begin
                    tx_idle_pct = 13;
                    rx_idle_pct <= 50;
                end
                1:
                begin
                    tx_idle_pct = 50;
                    rx_idle_pct <= 13;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            case (seg)
                0:
                begin
                    en = 1'b1;
                    up = 16'd500;
                    dn = 16'd200;
                end
                1:
                begin
                    en = 1'b1;
                    up = 16'd0;
                    dn = 16'hFFFF;
                end
                2:
                begin
                    en = 1'b0;
                    up = 16'hFFFF;
                    dn = 16'd0;
                end
                4:
                begin
                    en = 1'b1;
                    up = 16'd99;
                    dn = 16'd100;
                end
                default:
                begin
                    en = 1'b1;
                    up = 16'($urandom_range(1500));
                    dn = 16'($urandom_range(1500));
                end
            endcase
            write_reg(REG_RAMP_ENABLE, {15'($urandom), en});
            write_reg(REG_RAMP_UP_MS, up);
            write_reg(REG_RAMP_DOWN_MS, dn);

            sent = 0;
            while (sent < SEG_ITEMS)
            begin
                run = $urandom_range(99);
                if (run < 50)
                    op = OP_SET_SETPOINT;
                else if (run < 92)
                    op = OP_SET_OUTPUT;
                else if (run < 97)
                    op = OP_UNUSED;
                else
                    op = OP_TICK;
                case ($urandom_range(7))
                    0:       value = 16'h0000;
                    1:       value = 16'hFFFF;
                    2:       value = 16'($urandom_range(255));
                    default: value = 16'($urandom);
                endcase
                send_beat(op, 8'($urandom), 1'($urandom), value);
                sent++;
                run = $urandom_range(18);
                repeat (run)
                begin
                    send_beat(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom));
                    sent++;
                end
                // Now and then let every pending result drain first
                if ($urandom_range(49) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
